/* hw/rtl/wcat_pkg.sv */
// Package for the window credit and ack tracker.
// Holds field widths, opcodes, register indexes and the controller/datapath structs.
// No dependencies; compiled first.
package wcat_pkg;

   localparam int OP_W    = 2;
   localparam int PORT_W  = 16;
   localparam int SEQ_W   = 32;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 16;
   localparam int PKT_W   = 32;

   // Forward distances at or above half the sequence space are behind the base,
   // so only the low bits below the top one reach the divider.
   localparam int DIST_W = SEQ_W - 1;

   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_SEND = 2'd1;
   localparam logic [OP_W-1:0] OP_ACK  = 2'd2;

   localparam logic REG_WINDOW  = 1'b0;
   localparam logic REG_CONTROL = 1'b1;

   localparam logic [COUNT_W-1:0] WINDOW_RESET       = 16'd20;
   localparam logic [PORT_W-1:0]  CONTROL_PORT_RESET = 16'd60001;
   localparam logic [COUNT_W-1:0] CREDIT_RESET       = 16'd1;

   // The timestamp table depth must be a power of two.
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int MTU_BYTES_DEF   = 1448;

   typedef struct packed {
      logic load;
      logic tick;
      logic send;
      logic start;
      logic div_start;
      logic advance;
      logic read;
      logic check;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            port_match;
      logic            started;
      logic            dist_ok;
      logic            div_done;
      logic            out_free;
   } dp_status_type;

endpackage

/* hw/rtl/wcat_req_if.sv */
// Request channel interface of the window credit and ack tracker.
// Carries valid, ready and one request beat; depends on wcat_pkg.
interface wcat_req_if;
   import wcat_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [PORT_W-1:0] report_port;
   logic [SEQ_W-1:0]  seq_value;
   logic [TIME_W-1:0] now_us;

   modport source (output valid, output op, output report_port, output seq_value,
                   output now_us, input ready);
   modport sink (input valid, input op, input report_port, input seq_value,
                 input now_us, output ready);
endinterface

/* hw/rtl/wcat_rsp_if.sv */
// Result channel interface of the window credit and ack tracker.
// Carries valid, ready and one result beat; depends on wcat_pkg.
interface wcat_rsp_if;
   import wcat_pkg::*;

   logic               valid;
   logic               ready;
   logic               granted;
   logic [PKT_W-1:0]   packet_number;
   logic               delay_valid;
   logic [TIME_W-1:0]  delay_us;
   logic [COUNT_W-1:0] in_flight_count;
   logic [COUNT_W-1:0] credit_count;
   logic               is_started;

   modport source (output valid, output granted, output packet_number,
                   output delay_valid, output delay_us, output in_flight_count,
                   output credit_count, output is_started, input ready);
   modport sink (input valid, input granted, input packet_number,
                 input delay_valid, input delay_us, input in_flight_count,
                 input credit_count, input is_started, output ready);
endinterface

/* hw/rtl/wcat_ctrl.sv */
// Controller state machine of the window credit and ack tracker.
// Sequences accept, decode, division, table lookup and result commit; uses wcat_pkg.
module wcat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  wcat_pkg::dp_status_type status,
   output wcat_pkg::ctrl_cmd_type  cmd
);
   import wcat_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_CHECK  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            unique case (status.op)
               OP_TICK: cmd.tick = 1'b1;
               OP_SEND: cmd.send = 1'b1;
               OP_ACK: begin
                  if (status.port_match) begin
                     cmd.start = 1'b1;
                  end else if (status.started && status.dist_ok) begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_to_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DECODE)
      else $error("accepted beat did not move to decode");
   a_one_op_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.tick, cmd.send, cmd.start, cmd.div_start}))
      else $error("more than one operation command issued");
   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == S_IDLE && !cmd.commit))
      else $error("commit did not return to idle");
`endif

endmodule

/* hw/rtl/wcat_div.sv */
// Divider of a forward byte distance by the MTU, done as a constant reciprocal multiply.
// The operand is registered on start and the quotient in the cycle after; uses wcat_pkg.
module wcat_div #(
   parameter int MTU_BYTES = wcat_pkg::MTU_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wcat_pkg::DIST_W-1:0] dividend,
   output logic [wcat_pkg::DIST_W-1:0] quotient,
   output logic                       done
);
   import wcat_pkg::*;

   // With the shift set to the operand width plus ceil(log2 MTU), the rounded-up
   // reciprocal gives the exact floor quotient for every operand and fits in one
   // bit more than the operand.
   localparam int                 SHIFT      = DIST_W + $clog2(MTU_BYTES);
   localparam logic [63:0]        SCALE      = 64'd1 << SHIFT;
   localparam logic [63:0]        RECIP_WIDE = (SCALE + 64'(MTU_BYTES) - 64'd1)
                                               / 64'(MTU_BYTES);
   localparam int                 RECIP_W    = DIST_W + 1;
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_WIDE);
   localparam int                 PROD_W     = DIST_W + RECIP_W;

   logic [DIST_W-1:0] operand_ff, operand_in;
   logic [DIST_W-1:0] quo_ff, quo_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] product;

   assign product = PROD_W'(operand_ff) * PROD_W'(RECIP);

   always_comb begin
      operand_in = operand_ff;
      quo_in     = quo_ff;
      busy_in    = 1'b0;
      done_in    = 1'b0;
      if (start) begin
         operand_in = dividend;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in  = DIST_W'(product >> SHIFT);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      operand_ff <= operand_in;
      quo_ff     <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* hw/rtl/wcat_dp.sv */
// Datapath of the window credit and ack tracker: counters, timestamp RAM,
// divider and the result register. Uses wcat_pkg and wcat_div.
module wcat_dp #(
   parameter int TABLE_DEPTH = wcat_pkg::TABLE_DEPTH_DEF,
   parameter int MTU_BYTES   = wcat_pkg::MTU_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wcat_pkg::ctrl_cmd_type          cmd,
   output wcat_pkg::dp_status_type         status,
   input  logic [wcat_pkg::OP_W-1:0]       req_op,
   input  logic [wcat_pkg::PORT_W-1:0]     req_report_port,
   input  logic [wcat_pkg::SEQ_W-1:0]      req_seq_value,
   input  logic [wcat_pkg::TIME_W-1:0]     req_now_us,
   input  logic [wcat_pkg::COUNT_W-1:0]    window_packets,
   input  logic [wcat_pkg::PORT_W-1:0]     control_port,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_granted,
   output logic [wcat_pkg::PKT_W-1:0]      rsp_packet_number,
   output logic                           rsp_delay_valid,
   output logic [wcat_pkg::TIME_W-1:0]     rsp_delay_us,
   output logic [wcat_pkg::COUNT_W-1:0]    rsp_in_flight_count,
   output logic [wcat_pkg::COUNT_W-1:0]    rsp_credit_count,
   output logic                           rsp_is_started
);
   import wcat_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W = 1 + PKT_W + TIME_W;

   // Entry layout: valid, tag, send time.
   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] ram_q_ff;
   logic               rd_written_ff, rd_written_in;

   logic [OP_W-1:0]    op_ff;
   logic [PORT_W-1:0]  port_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [TIME_W-1:0]  now_ff;

   logic [COUNT_W-1:0] credits_ff, credits_in;
   logic [COUNT_W-1:0] in_flight_ff, in_flight_in;
   logic [PKT_W-1:0]   next_packet_ff, next_packet_in;
   logic [PKT_W-1:0]   acked_ff, acked_in;
   logic [PKT_W-1:0]   last_acked_ff, last_acked_in;
   logic [SEQ_W-1:0]   base_ff, base_in;
   logic               started_ff, started_in;
   logic               filled_ff, filled_in;

   logic               granted_ff, granted_in;
   logic [PKT_W-1:0]   pkt_ff, pkt_in;
   logic               dvalid_ff, dvalid_in;
   logic [TIME_W-1:0]  delay_ff, delay_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff;
   logic [PKT_W-1:0]   rsp_pkt_ff;
   logic               rsp_dvalid_ff;
   logic [TIME_W-1:0]  rsp_delay_ff;
   logic [COUNT_W-1:0] rsp_in_flight_ff;
   logic [COUNT_W-1:0] rsp_credits_ff;
   logic               rsp_started_ff;

   logic [SEQ_W-1:0]   byte_gap;
   logic [DIST_W-1:0]  div_quo;
   logic               div_done;
   logic [PKT_W-1:0]   np;
   logic [IDX_W-1:0]   np_slot;
   logic [IDX_W-1:0]   ack_slot;
   logic [COUNT_W:0]   used;
   logic               credit_nz;
   logic               hit;
   logic [PKT_W-1:0]   fresh_raw;
   logic [PKT_W-1:0]   fresh;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               out_free;

   assign byte_gap  = seq_ff - base_ff;
   assign np        = next_packet_ff + 1'b1;
   assign np_slot   = np[IDX_W-1:0];
   assign ack_slot  = acked_ff[IDX_W-1:0];
   assign used      = {1'b0, in_flight_ff} + {1'b0, credits_ff};
   assign credit_nz = credits_ff != '0;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Slots fill in packet order starting at one, so until the first wrap a slot
   // holds data only if it lies at or below the newest packet number.
   assign rd_written_in = filled_ff || (ack_slot != '0 && ack_slot <= next_packet_ff[IDX_W-1:0]);

   assign hit = rd_written_ff && ram_q_ff[ENTRY_W-1]
                && ram_q_ff[PKT_W+TIME_W-1:TIME_W] == acked_ff;

   // Acked counts behind last_acked release nothing.
   assign fresh_raw = acked_ff - last_acked_ff;
   assign fresh     = fresh_raw[PKT_W-1] ? '0 : fresh_raw;

   assign status.op         = op_ff;
   assign status.port_match = port_ff == control_port;
   assign status.started    = started_ff;
   assign status.dist_ok    = !byte_gap[SEQ_W-1];
   assign status.div_done   = div_done;
   assign status.out_free   = out_free;

   wcat_div #(
      .MTU_BYTES(MTU_BYTES)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(byte_gap[DIST_W-1:0]),
      .quotient(div_quo),
      .done    (div_done)
   );

   always_comb begin
      credits_in     = credits_ff;
      in_flight_in   = in_flight_ff;
      next_packet_in = next_packet_ff;
      acked_in       = acked_ff;
      last_acked_in  = last_acked_ff;
      base_in        = base_ff;
      started_in     = started_ff;
      filled_in      = filled_ff;
      granted_in     = granted_ff;
      pkt_in         = pkt_ff;
      dvalid_in      = dvalid_ff;
      delay_in       = delay_ff;
      mem_we         = 1'b0;
      mem_waddr      = ack_slot;
      mem_wdata      = {1'b0, ram_q_ff[ENTRY_W-2:0]};

      if (cmd.load) begin
         granted_in = 1'b0;
         pkt_in     = '0;
         dvalid_in  = 1'b0;
         delay_in   = '0;
      end

      if (cmd.tick && started_ff && ({1'b0, window_packets} > used)) begin
         credits_in = window_packets - in_flight_ff;
      end

      if (cmd.send && credit_nz) begin
         credits_in     = credits_ff - 1'b1;
         next_packet_in = np;
         if (in_flight_ff != '1) begin
            in_flight_in = in_flight_ff + 1'b1;
         end
         if (np_slot == '0) begin
            filled_in = 1'b1;
         end
         mem_we     = 1'b1;
         mem_waddr  = np_slot;
         mem_wdata  = {1'b1, np, now_ff};
         granted_in = 1'b1;
         pkt_in     = np;
      end

      if (cmd.start && !started_ff) begin
         base_in    = seq_ff;
         started_in = 1'b1;
      end

      if (cmd.advance) begin
         acked_in = acked_ff + {1'b0, div_quo};
         base_in  = seq_ff;
      end

      if (cmd.check && hit) begin
         dvalid_in = 1'b1;
         delay_in  = now_ff - ram_q_ff[TIME_W-1:0];
         if (fresh >= {{(PKT_W-COUNT_W){1'b0}}, in_flight_ff}) begin
            in_flight_in = '0;
         end else begin
            in_flight_in = in_flight_ff - fresh[COUNT_W-1:0];
         end
         if (fresh != '0) begin
            last_acked_in = acked_ff;
         end
         mem_we = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff     <= CREDIT_RESET;
         in_flight_ff   <= '0;
         next_packet_ff <= '0;
         acked_ff       <= '0;
         last_acked_ff  <= '0;
         base_ff        <= '0;
         started_ff     <= 1'b0;
         filled_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         credits_ff     <= credits_in;
         in_flight_ff   <= in_flight_in;
         next_packet_ff <= next_packet_in;
         acked_ff       <= acked_in;
         last_acked_ff  <= last_acked_in;
         base_ff        <= base_in;
         started_ff     <= started_in;
         filled_ff      <= filled_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         port_ff <= req_report_port;
         seq_ff  <= req_seq_value;
         now_ff  <= req_now_us;
      end
      granted_ff <= granted_in;
      pkt_ff     <= pkt_in;
      dvalid_ff  <= dvalid_in;
      delay_ff   <= delay_in;
      if (cmd.commit) begin
         rsp_granted_ff   <= granted_ff;
         rsp_pkt_ff       <= pkt_ff;
         rsp_dvalid_ff    <= dvalid_ff;
         rsp_delay_ff     <= delay_ff;
         rsp_in_flight_ff <= in_flight_ff;
         rsp_credits_ff   <= credits_ff;
         rsp_started_ff   <= started_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         ram_q_ff      <= mem[ack_slot];
         rd_written_ff <= rd_written_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted         = rsp_granted_ff;
   assign rsp_packet_number   = rsp_pkt_ff;
   assign rsp_delay_valid     = rsp_dvalid_ff;
   assign rsp_delay_us        = rsp_delay_ff;
   assign rsp_in_flight_count = rsp_in_flight_ff;
   assign rsp_credit_count    = rsp_credits_ff;
   assign rsp_is_started      = rsp_started_ff;

`ifndef NO_ASSERTIONS
   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped");
   a_send_numbers: assert property (@(posedge clock) disable iff (reset)
      (cmd.send && credit_nz) |=> next_packet_ff == $past(next_packet_ff) + 32'd1)
      else $error("granted send did not number the packet");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("result committed over an unread result");
`endif

endmodule

/* hw/rtl/window_credit_ack_tracker.sv */
// Top level of the window credit and ack tracker.
// Holds the APB register file and joins wcat_ctrl and wcat_dp; uses wcat_pkg and the
// wcat_req_if / wcat_rsp_if channel interfaces.
//
// Usage: each request beat on req (tick, send request or ack report) yields exactly
// one result beat on rsp carrying the grant, packet number, delay sample and the
// counters as they stand after the request. One request is in work at a time.
// A tick, a send request, a start report or an ignored report passes through the
// decode and done states; its result is registered on commit, and the next request
// beat is taken only after that commit. An ack report that moves the base also
// passes through the divide, read and check states: the byte distance is registered
// and multiplied by a constant reciprocal of the MTU into a registered quotient, the
// acked count then advances, and the timestamp RAM takes one registered read and one
// compare-and-clear step.
// window_packets (0x0) and control_port (0x4) are to be written over APB only while
// the block is idle; the block itself does not enforce this.
// Reset restores the counters and register defaults and empties the timestamp table
// at once, with no clearing pass: slots are tracked by the packet fill count.
// When the receiver stalls, the finished result waits in the output register; the
// block still takes the next request, works it, and holds before committing it.
module window_credit_ack_tracker #(
   parameter int TABLE_DEPTH = wcat_pkg::TABLE_DEPTH_DEF,
   parameter int MTU_BYTES   = wcat_pkg::MTU_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   wcat_req_if.sink    req,
   wcat_rsp_if.source  rsp
);
   import wcat_pkg::*;

   logic [COUNT_W-1:0] window_ff, window_in;
   logic [PORT_W-1:0]  control_ff, control_in;
   logic               csr_wr;
   logic               csr_index;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      window_in  = window_ff;
      control_in = control_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_WINDOW:  window_in  = csr_pwdata[COUNT_W-1:0];
            REG_CONTROL: control_in = csr_pwdata[PORT_W-1:0];
            default:     window_in  = window_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WINDOW:  csr_prdata = {{(32-COUNT_W){1'b0}}, window_ff};
         REG_CONTROL: csr_prdata = {{(32-PORT_W){1'b0}}, control_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         control_ff <= CONTROL_PORT_RESET;
      end else begin
         window_ff  <= window_in;
         control_ff <= control_in;
      end
   end

   wcat_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .status   (status),
      .cmd      (cmd)
   );

   wcat_dp #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .MTU_BYTES  (MTU_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req.op),
      .req_report_port    (req.report_port),
      .req_seq_value      (req.seq_value),
      .req_now_us         (req.now_us),
      .window_packets     (window_ff),
      .control_port       (control_ff),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_granted        (rsp.granted),
      .rsp_packet_number  (rsp.packet_number),
      .rsp_delay_valid    (rsp.delay_valid),
      .rsp_delay_us       (rsp.delay_us),
      .rsp_in_flight_count(rsp.in_flight_count),
      .rsp_credit_count   (rsp.credit_count),
      .rsp_is_started     (rsp.is_started)
   );

endmodule

/* verif/window_credit_ack_tracker_tb.sv */
// Self-checking testbench for the window credit and ack tracker.
// Holds a predictor of credits, in-flight count and delay samples; depends on wcat_pkg,
// wcat_req_if, wcat_rsp_if and the window_credit_ack_tracker RTL.
`timescale 1ns / 1ps

module window_credit_ack_tracker_tb;
   import wcat_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
   localparam logic [2:0]      ADDR_WINDOW  = {REG_WINDOW, 2'b00};
   localparam logic [2:0]      ADDR_CONTROL = {REG_CONTROL, 2'b00};
   localparam int              STAMP_DEPTH  = TABLE_DEPTH_DEF;
   localparam logic [31:0]     MTU          = MTU_BYTES_DEF;
   localparam logic [31:0]     HALF_SPACE   = 32'h8000_0000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PORT_W-1:0] report_port;
      logic [SEQ_W-1:0]  seq_value;
      logic [TIME_W-1:0] now_us;
   } request_beat_type;

   typedef struct packed {
      logic               granted;
      logic [PKT_W-1:0]   packet_number;
      logic               delay_valid;
      logic [TIME_W-1:0]  delay_us;
      logic [COUNT_W-1:0] in_flight_count;
      logic [COUNT_W-1:0] credit_count;
      logic               is_started;
   } result_beat_type;

   class window_credit_predictor_type;
      logic [COUNT_W-1:0] window_packets;
      logic [PORT_W-1:0]  control_port;
      logic [COUNT_W-1:0] credits;
      logic [COUNT_W-1:0] in_flight;
      logic [PKT_W-1:0]   next_packet;
      logic [31:0]        acked_packets;
      logic [31:0]        last_acked;
      logic [SEQ_W-1:0]   base_seq;
      logic               started;
      logic [TIME_W-1:0]  stamp_time [STAMP_DEPTH];
      logic [PKT_W-1:0]   stamp_tag [STAMP_DEPTH];
      logic               stamp_valid [STAMP_DEPTH];
      result_beat_type    pending_results [$];
      int unsigned        mismatches;

      function new();
         window_packets = WINDOW_RESET;
         control_port   = CONTROL_PORT_RESET;
         credits        = CREDIT_RESET;
         in_flight      = '0;
         next_packet    = '0;
         acked_packets  = '0;
         last_acked     = '0;
         base_seq       = '0;
         started        = 1'b0;
         mismatches     = 0;
         for (int s = 0; s < STAMP_DEPTH; s++) begin
            stamp_valid[s] = 1'b0;
         end
      endfunction

      function void write_reg(logic [2:0] addr, logic [31:0] data);
         if (addr == ADDR_WINDOW) begin
            window_packets = data[15:0];
         end else if (addr == ADDR_CONTROL) begin
            control_port = data[15:0];
         end
      endfunction

      function void note_request(request_beat_type r);
         result_beat_type want;
         logic [16:0]     used;
         logic [31:0]     byte_gap;
         logic [31:0]     fresh;
         int unsigned     slot;
         want = '0;
         case (r.op)
            OP_TICK: begin
               used = {1'b0, in_flight} + {1'b0, credits};
               if (started && ({1'b0, window_packets} > used)) begin
                  credits = window_packets - in_flight;
               end
            end
            OP_SEND: begin
               if (credits != 0) begin
                  credits     = credits - 1'b1;
                  next_packet = next_packet + 1;
                  if (in_flight != 16'hFFFF) begin
                     in_flight = in_flight + 1'b1;
                  end
                  slot              = next_packet % STAMP_DEPTH;
                  stamp_time[slot]  = r.now_us;
                  stamp_tag[slot]   = next_packet;
                  stamp_valid[slot] = 1'b1;
                  want.granted       = 1'b1;
                  want.packet_number = next_packet;
               end
            end
            OP_ACK: begin
               if (r.report_port == control_port) begin
                  if (!started) begin
                     base_seq = r.seq_value;
                     started  = 1'b1;
                  end
               end else if (started) begin
                  byte_gap = r.seq_value - base_seq;
                  // A forward distance of half the space or more is behind the base.
                  if (byte_gap < HALF_SPACE) begin
                     acked_packets = acked_packets + byte_gap / MTU;
                     base_seq      = r.seq_value;
                     slot          = acked_packets % STAMP_DEPTH;
                     if (stamp_valid[slot] && stamp_tag[slot] == acked_packets) begin
                        fresh            = acked_packets - last_acked;
                        want.delay_valid = 1'b1;
                        want.delay_us    = r.now_us - stamp_time[slot];
                        if (fresh >= HALF_SPACE) begin
                           fresh = '0;
                        end
                        if (fresh >= {16'b0, in_flight}) begin
                           in_flight = '0;
                        end else begin
                           in_flight = in_flight - fresh[15:0];
                        end
                        if (fresh != 0) begin
                           last_acked = acked_packets;
                        end
                        stamp_valid[slot] = 1'b0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         want.in_flight_count = in_flight;
         want.credit_count    = credits;
         want.is_started      = started;
         pending_results.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_beat_type got);
         result_beat_type want;
         if (pending_results.size() == 0) begin
            $error("result beat arrived with no request waiting for it");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("granted", 32'(want.granted), 32'(got.granted));
         compare_field("packet_number", want.packet_number, got.packet_number);
         compare_field("delay_valid", 32'(want.delay_valid), 32'(got.delay_valid));
         compare_field("delay_us", want.delay_us, got.delay_us);
         compare_field("in_flight_count", 32'(want.in_flight_count),
                       32'(got.in_flight_count));
         compare_field("credit_count", 32'(want.credit_count), 32'(got.credit_count));
         compare_field("is_started", 32'(want.is_started), 32'(got.is_started));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wcat_req_if req_ch ();
   wcat_rsp_if rsp_ch ();

   window_credit_ack_tracker uut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   window_credit_predictor_type sb = new();
   logic                        calm = 1'b0;
   logic [TIME_W-1:0]           clock_us;
   int unsigned                 stall_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Random idle length; calm stretches run with no idling at all.
   function automatic int unsigned idle_gap();
      int unsigned r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PORT_W-1:0] any_port();
      return PORT_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [PORT_W-1:0] other_port();
      logic [PORT_W-1:0] p;
      p = any_port();
      while (p == sb.control_port) begin
         p = any_port();
      end
      return p;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request({req_ch.op, req_ch.report_port, req_ch.seq_value, req_ch.now_us});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result({rsp_ch.granted, rsp_ch.packet_number, rsp_ch.delay_valid,
                             rsp_ch.delay_us, rsp_ch.in_flight_count, rsp_ch.credit_count,
                             rsp_ch.is_started});
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            sb.write_reg(csr_paddr, csr_pwdata);
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready = 1'b1;
         stall_left = idle_gap();
      end
   end

   // Called at a falling edge; returns at a falling edge after the beat is taken.
   task automatic push_req(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                           input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] now);
      int unsigned gap;
      req_ch.valid       = 1'b1;
      req_ch.op          = op;
      req_ch.report_port = port;
      req_ch.seq_value   = seq;
      req_ch.now_us      = now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      gap = idle_gap();
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic random_item();
      int unsigned       r;
      logic [31:0]       outstanding;
      logic [31:0]       k;
      logic [SEQ_W-1:0]  seq;
      if ($urandom_range(0, 29) == 0) begin
         calm = !calm;
      end
      if ($urandom_range(0, 49) == 0) begin
         clock_us = $urandom;
      end else begin
         clock_us = clock_us + $urandom_range(1, 300);
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
         push_req(OP_TICK, any_port(), $urandom, clock_us);
      end else if (r < 55) begin
         push_req(OP_SEND, any_port(), $urandom, clock_us);
      end else if (r < 85) begin
         // Cumulative ack that lands on a packet number, with a random byte residue.
         outstanding = sb.next_packet - sb.acked_packets;
         if (outstanding == 0 || outstanding[31]) begin
            k = $urandom_range(0, 1);
         end else if ($urandom_range(0, 19) == 0) begin
            k = outstanding + $urandom_range(1, 5);
         end else begin
            k = $urandom_range(1, (outstanding > 4) ? 4 : outstanding);
         end
         seq = sb.base_seq + k * MTU + $urandom_range(0, MTU - 1);
         push_req(OP_ACK, other_port(), seq, clock_us);
      end else if (r < 88) begin
         push_req(OP_ACK, sb.control_port, $urandom, clock_us);
      end else if (r < 92) begin
         push_req(OP_UNUSED, any_port(), $urandom, $urandom);
      end else begin
         push_req(OP_ACK, any_port(), $urandom, clock_us);
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] windows [5];
      logic [PORT_W-1:0]  ports [5];
      reset           = 1'b1;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      req_ch.valid    = 1'b0;
      req_ch.op       = OP_TICK;
      req_ch.report_port = '0;
      req_ch.seq_value   = '0;
      req_ch.now_us      = '0;
      rsp_ch.ready    = 1'b0;
      clock_us        = $urandom;
      windows = '{16'd20, 16'd1, 16'd65535, 16'd2, 16'($urandom_range(1, 65535))};
      ports   = '{16'd60001, 16'd0, 16'd65535, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535))};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, run on the register values left by reset.
      push_req(OP_TICK, 16'd0, 32'd0, 32'd0);
      push_req(OP_SEND, 16'd0, 32'd0, 32'd0);
      push_req(OP_SEND, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(OP_ACK, 16'd0, 32'hFFFF_FFFF, 32'd0);
      push_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(OP_ACK, CONTROL_PORT_RESET, 32'hFFFF_F800, 32'd100);
      push_req(OP_ACK, CONTROL_PORT_RESET, 32'd0, 32'd110);
      push_req(OP_TICK, 16'd0, 32'd0, 32'd150);
      push_req(OP_SEND, 16'd0, 32'd0, 32'd200);
      push_req(OP_SEND, 16'd0, 32'd0, 32'd300);
      push_req(OP_SEND, 16'd0, 32'd0, 32'd400);
      push_req(OP_ACK, 16'hFFFF, sb.base_seq - 1, 32'd450);
      push_req(OP_ACK, 16'd1, sb.base_seq + HALF_SPACE, 32'd460);
      // The third ack report from here carries the sequence number across zero.
      push_req(OP_ACK, 16'd1, sb.base_seq + MTU, 32'd500);
      push_req(OP_ACK, 16'd1, sb.base_seq + 32'd100, 32'd510);
      push_req(OP_ACK, 16'd1, sb.base_seq + 2 * MTU, 32'd600);
      push_req(OP_ACK, 16'd1, sb.base_seq + 3 * MTU + MTU - 1, 32'd700);
      push_req(OP_TICK, 16'd0, 32'd0, 32'd800);
      push_req(OP_SEND, 16'd0, 32'd0, 32'hFFFF_FFF0);
      push_req(OP_SEND, 16'd0, 32'd0, 32'hFFFF_FFF8);
      push_req(OP_ACK, 16'd1, sb.base_seq, 32'h0000_0010);

      for (int ph = 0; ph < 5; ph++) begin
         req_ch.valid = 1'b0;
         wait_drained();
         repeat (4) @(negedge clock);
         csr_write(ADDR_WINDOW, {16'd0, windows[ph]});
         csr_write(ADDR_CONTROL, {16'd0, ports[ph]});
         if (ph == 2) begin
            // Fill past the table depth so that slots get reused before the acks.
            push_req(OP_TICK, 16'd0, 32'd0, clock_us);
            for (int n = 0; n < STAMP_DEPTH + 14; n++) begin
               clock_us = clock_us + $urandom_range(1, 20);
               push_req(OP_SEND, any_port(), $urandom, clock_us);
            end
         end
         for (int i = 0; i < 45; i++) begin
            if (i == 22) begin
               req_ch.valid = 1'b0;
               wait_drained();
            end
            random_item();
         end
      end

      req_ch.valid = 1'b0;
      wait_drained();
      repeat (60) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
